// ===== design/wdu_pkg.sv =====
package wdu_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned DiffWidth  = CoordWidth + 2;
  localparam int unsigned NormBits   = 31;
  localparam int unsigned SumWidth   = 2 * NormBits + 2;
  localparam int unsigned RootWidth  = SumWidth / 2;
  localparam int unsigned RemWidth   = RootWidth + 2;
  localparam int unsigned QuotBits   = 15;
  localparam int unsigned NumWidth   = NormBits + QuotBits + 1;
  localparam int unsigned OutWidth   = 16;
  localparam int unsigned LenWidth   = $clog2(DiffWidth + 1);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [OutWidth-1:0]   comp_t;

  // normalized components and flags that ride along the root chain
  typedef struct packed {
    logic [2:0][NormBits-1:0] a;
    logic [2:0]               neg;
    logic                     zero;
    logic                     frame;
  } side_t;

  typedef struct packed {
    logic [SumWidth-1:0]  s;
    logic [RemWidth-1:0]  rem;
    logic [RootWidth-1:0] root;
    side_t                side;
  } sq_t;

  typedef struct packed {
    logic [2:0][NumWidth-1:0] rem;
    logic [NumWidth-1:0]      dsh;
    logic [2:0][QuotBits-1:0] q;
    logic [2:0]               neg;
    logic                     zero;
    logic                     frame;
  } dv_t;

endpackage

// ===== design/wdu_if.sv =====
interface wdu_in_if;
  import wdu_pkg::*;
  logic   valid;
  logic   ready;
  coord_t oxygen_x;
  coord_t oxygen_y;
  coord_t oxygen_z;
  coord_t first_h_x;
  coord_t first_h_y;
  coord_t first_h_z;
  coord_t second_h_x;
  coord_t second_h_y;
  coord_t second_h_z;
  logic   last_in_frame;

  modport source (output valid, oxygen_x, oxygen_y, oxygen_z, first_h_x, first_h_y,
                  first_h_z, second_h_x, second_h_y, second_h_z, last_in_frame,
                  input ready);
  modport sink (input valid, oxygen_x, oxygen_y, oxygen_z, first_h_x, first_h_y,
                first_h_z, second_h_x, second_h_y, second_h_z, last_in_frame,
                output ready);
endinterface

interface wdu_out_if;
  import wdu_pkg::*;
  logic  valid;
  logic  ready;
  comp_t dipole_x;
  comp_t dipole_y;
  comp_t dipole_z;
  logic  zero_length;
  logic  frame_end;

  modport source (output valid, dipole_x, dipole_y, dipole_z, zero_length, frame_end,
                  input ready);
  modport sink (input valid, dipole_x, dipole_y, dipole_z, zero_length, frame_end,
                output ready);
endinterface

// ===== design/wdu_front.sv =====
module wdu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  wdu_pkg::coord_t    o_i [3],
  input  wdu_pkg::coord_t    h1_i [3],
  input  wdu_pkg::coord_t    h2_i [3],
  input  logic               frame_i,
  output logic               valid_o,
  input  logic               ready_i,
  output wdu_pkg::sq_t       data_o
);
  import wdu_pkg::*;

  // stage 1: magnitude and sign
  logic [2:0][DiffWidth-1:0] mag_q, mag_d;
  logic [2:0]                neg1_q, neg1_d;
  logic                      fr1_q;
  // stage 2: normalized magnitudes
  side_t                     side2_q, side2_d;
  // stage 3: squares
  logic [2:0][2*NormBits-1:0] sq3_q, sq3_d;
  side_t                     side3_q;
  // stage 4: sum
  logic [SumWidth-1:0]       sum4_q, sum4_d;
  side_t                     side4_q;

  logic [3:0] vld_q;
  logic [3:0] en;

  // stage enables: a stage loads when empty or its contents move on
  assign en[3]   = !vld_q[3] || ready_i;
  assign en[2]   = !vld_q[2] || en[3];
  assign en[1]   = !vld_q[1] || en[2];
  assign en[0]   = !vld_q[0] || en[1];
  assign ready_o = en[0];
  assign valid_o = vld_q[3];

  // form twice the dipole and split sign from magnitude
  always_comb begin
    logic signed [DiffWidth-1:0] d;
    for (int i = 0; i < 3; i++) begin
      d = DiffWidth'(h1_i[i]) + DiffWidth'(h2_i[i]) - (DiffWidth'(o_i[i]) <<< 1);
      neg1_d[i] = d[DiffWidth-1];
      mag_d[i]  = d[DiffWidth-1] ? DiffWidth'(-d) : DiffWidth'(d);
    end
  end

  // scale so the largest magnitude lands in the top normalized bit
  always_comb begin
    logic [DiffWidth-1:0]          orv;
    logic [LenWidth-1:0]           len;
    logic [DiffWidth+NormBits-1:0] tmp;
    orv = mag_q[0] | mag_q[1] | mag_q[2];
    len = '0;
    for (int b = 0; b < DiffWidth; b++) begin
      if (orv[b]) len = LenWidth'(b + 1);
    end
    for (int i = 0; i < 3; i++) begin
      tmp = (DiffWidth+NormBits)'(mag_q[i]);
      if (len < LenWidth'(NormBits)) tmp = tmp << (LenWidth'(NormBits) - len);
      else                           tmp = tmp >> (len - LenWidth'(NormBits));
      side2_d.a[i] = tmp[NormBits-1:0];
    end
    side2_d.neg   = neg1_q;
    side2_d.zero  = (orv == '0);
    side2_d.frame = fr1_q;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq3_d[i] = (2*NormBits)'(side2_q.a[i]) * (2*NormBits)'(side2_q.a[i]);
    end
    sum4_d = SumWidth'(sq3_q[0]) + SumWidth'(sq3_q[1]) + SumWidth'(sq3_q[2]);
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
    end
  end

  // hold payload unless the stage loads
  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      mag_q  <= mag_d;
      neg1_q <= neg1_d;
      fr1_q  <= frame_i;
    end
    if (en[1] && vld_q[0]) side2_q <= side2_d;
    if (en[2] && vld_q[1]) begin
      sq3_q   <= sq3_d;
      side3_q <= side2_q;
    end
    if (en[3] && vld_q[2]) begin
      sum4_q  <= sum4_d;
      side4_q <= side3_q;
    end
  end

  always_comb begin
    data_o.s    = sum4_q;
    data_o.rem  = '0;
    data_o.root = '0;
    data_o.side = side4_q;
  end

endmodule

// ===== design/wdu_sqrt_cell.sv =====
module wdu_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  wdu_pkg::sq_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output wdu_pkg::sq_t  data_o
);
  import wdu_pkg::*;

  logic valid_q;
  sq_t  data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // one root bit: bring down two radicand bits and try the trial subtract
  always_comb begin
    logic [RemWidth+1:0] cur;
    logic [RemWidth+1:0] trial;
    cur   = {data_i.rem, data_i.s[SumWidth-1 -: 2]};
    trial = (RemWidth+2)'({data_i.root, 2'b01});
    data_d      = data_i;
    data_d.s    = data_i.s << 2;
    if (cur >= trial) begin
      data_d.rem  = RemWidth'(cur - trial);
      data_d.root = {data_i.root[RootWidth-2:0], 1'b1};
    end else begin
      data_d.rem  = RemWidth'(cur);
      data_d.root = {data_i.root[RootWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (ready_o) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

// ===== design/wdu_div_cell.sv =====
module wdu_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  wdu_pkg::dv_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output wdu_pkg::dv_t  data_o
);
  import wdu_pkg::*;

  logic valid_q;
  dv_t  data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // one quotient bit per lane against the shifted divisor
  always_comb begin
    data_d     = data_i;
    data_d.dsh = data_i.dsh >> 1;
    for (int i = 0; i < 3; i++) begin
      if (data_i.rem[i] >= data_i.dsh) begin
        data_d.rem[i] = data_i.rem[i] - data_i.dsh;
        data_d.q[i]   = {data_i.q[i][QuotBits-2:0], 1'b1};
      end else begin
        data_d.q[i]   = {data_i.q[i][QuotBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (ready_o) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

// ===== design/water_dipole_unit_vector_unit.sv =====
// Pipeline: 4 front stages, 32 square-root cells (one root bit each), 15 divider
// cells (one quotient bit each). Throughput while out_o.ready is high: one molecule
// per cycle; every cell then hands its beat on each cycle.
// Each cell loads when empty or when its beat moves on, so bubbles close up.
// Reset clears the valid bits of all stages; payload registers are not reset.
module water_dipole_unit_vector_unit (
  input  logic clk_i,
  input  logic rst_ni,
  wdu_in_if.sink    in_i,
  wdu_out_if.source out_o
);
  import wdu_pkg::*;

  localparam int unsigned SqrtCells = RootWidth;

  coord_t o [3];
  coord_t h1 [3];
  coord_t h2 [3];

  assign o[0]  = in_i.oxygen_x;
  assign o[1]  = in_i.oxygen_y;
  assign o[2]  = in_i.oxygen_z;
  assign h1[0] = in_i.first_h_x;
  assign h1[1] = in_i.first_h_y;
  assign h1[2] = in_i.first_h_z;
  assign h2[0] = in_i.second_h_x;
  assign h2[1] = in_i.second_h_y;
  assign h2[2] = in_i.second_h_z;

  logic sq_vld [SqrtCells+1];
  logic sq_rdy [SqrtCells+1];
  sq_t  sq_dat [SqrtCells+1];

  logic dv_vld [QuotBits+1];
  logic dv_rdy [QuotBits+1];
  dv_t  dv_dat [QuotBits+1];

  wdu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .o_i     (o),
    .h1_i    (h1),
    .h2_i    (h2),
    .frame_i (in_i.last_in_frame),
    .valid_o (sq_vld[0]),
    .ready_i (sq_rdy[0]),
    .data_o  (sq_dat[0])
  );

  for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
    wdu_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld[k]),
      .ready_o (sq_rdy[k]),
      .data_i  (sq_dat[k]),
      .valid_o (sq_vld[k+1]),
      .ready_i (sq_rdy[k+1]),
      .data_o  (sq_dat[k+1])
    );
  end

  // set up numerators a*2^15 + m and divisor 2m aligned to the top quotient bit
  always_comb begin
    logic [RootWidth-1:0] m;
    m = sq_dat[SqrtCells].root;
    for (int i = 0; i < 3; i++) begin
      dv_dat[0].rem[i] = (NumWidth'(sq_dat[SqrtCells].side.a[i]) << QuotBits)
                         + NumWidth'(m);
      dv_dat[0].q[i]   = '0;
    end
    dv_dat[0].dsh   = NumWidth'(m) << QuotBits;
    dv_dat[0].neg   = sq_dat[SqrtCells].side.neg;
    dv_dat[0].zero  = sq_dat[SqrtCells].side.zero;
    dv_dat[0].frame = sq_dat[SqrtCells].side.frame;
  end
  assign dv_vld[0]          = sq_vld[SqrtCells];
  assign sq_rdy[SqrtCells]  = dv_rdy[0];

  for (genvar k = 0; k < QuotBits; k++) begin : g_div
    wdu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_vld[k]),
      .ready_o (dv_rdy[k]),
      .data_i  (dv_dat[k]),
      .valid_o (dv_vld[k+1]),
      .ready_i (dv_rdy[k+1]),
      .data_o  (dv_dat[k+1])
    );
  end

  assign out_o.valid        = dv_vld[QuotBits];
  assign dv_rdy[QuotBits]   = out_o.ready;

  // apply sign and drop the zero-length case
  always_comb begin
    comp_t c [3];
    for (int i = 0; i < 3; i++) begin
      c[i] = comp_t'({1'b0, dv_dat[QuotBits].q[i]});
      if (dv_dat[QuotBits].neg[i]) c[i] = -c[i];
      if (dv_dat[QuotBits].zero)   c[i] = '0;
    end
    out_o.dipole_x    = c[0];
    out_o.dipole_y    = c[1];
    out_o.dipole_z    = c[2];
    out_o.zero_length = dv_dat[QuotBits].zero;
    out_o.frame_end   = dv_dat[QuotBits].frame;
  end

endmodule
